// ===== rtl/msb_first_bit_packer_defines.svh =====
// Assertion macros shared by the bit packer RTL.
// Each macro expects aclk and aresetn to be visible at the point of use.
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MFBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mfbp_pkg.sv =====
// Package for the MSB-first bit packer: action codes, sequencer states,
// limits and the structs passed to the shared merge unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfbp_pkg;

    localparam int MAX_CODE_BITS = 32;
    localparam int CODE_CAP      = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
    localparam logic [5:0] CODE_CAP_W = 6'(CODE_CAP);
    localparam logic [5:0] BYTE_BITS  = 6'd8;
    localparam logic [5:0] WORD_BITS  = 6'd32;

    typedef enum logic [1:0] {
        ACT_CODE   = 2'd0,
        ACT_BYTE   = 2'd1,
        ACT_WORD   = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        logic [6:0]  pend;
        logic [2:0]  cnt;
        logic [31:0] sr;
        logic [5:0]  rem;
    } step_in_t;

    typedef struct packed {
        logic        emit;
        logic        last;
        logic [7:0]  obyte;
        logic [6:0]  pend;
        logic [2:0]  cnt;
        logic [31:0] sr;
        logic [5:0]  rem;
    } step_out_t;

endpackage

`default_nettype wire

// ===== rtl/msb_first_bit_packer.sv =====
// MSB-first bit packer top level: sequencer, queue state and output register.
// Depends on mfbp_pkg, mfbp_merge_unit and msb_first_bit_packer_defines.svh.
//
// Usage:
//   Input items arrive on the s_ stream. s_tuser carries the action (code,
//   byte, word, finish); s_tdata carries value in bits 31:0 and length in
//   bits 37:32. Packed bytes leave on the m_ stream, one per transfer, with
//   the oldest queued bit in bit 7 and m_tlast high on the final byte
//   produced by an input item.
// Timing:
//   An accepted item takes one merge step per output byte, plus one more when
//   leftover bits must be absorbed or no byte comes out; a step waits for a
//   free output register. A word takes 4 or 5 steps, a byte 1 or 2, a code 1
//   to 5, a finish 1. The accepting edge loads the item into the shift
//   register; a merge step then writes the first byte to the output register.
//   s_tready is high only while the sequencer is idle, but the last byte of
//   the previous item may still sit in the output register meanwhile.
// Reset:
//   aresetn is synchronous and active low; it empties the bit queue, drops
//   any byte held in the output register and returns the sequencer to idle.
// Back-pressure:
//   While m_tready is low the output register holds its byte and the merge
//   unit stalls, so no byte is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "msb_first_bit_packer_defines.svh"

module msb_first_bit_packer
    import mfbp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata fields from bit 0: value[31:0], length[37:32], zero fill[39:38]
    input  wire logic [39:0] s_tdata,
    // s_tuser fields from bit 0: action[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata fields from bit 0: out_byte[7:0]
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    state_t      state_reg, state_next;
    logic [6:0]  pend_reg, pend_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] sr_reg, sr_next;
    logic [5:0]  rem_reg, rem_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    logic        ovalid_reg, ovalid_next;

    step_in_t    step_in;
    step_out_t   step_out;
    logic        in_accept;
    logic        out_free;
    logic [31:0] in_value;
    logic [5:0]  in_length;

    assign step_in = '{pend: pend_reg, cnt: cnt_reg, sr: sr_reg, rem: rem_reg};

    mfbp_merge_unit u_merge (
        .si (step_in),
        .so (step_out)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !ovalid_reg || m_tready;
    assign in_value  = s_tdata[31:0];
    assign in_length = s_tdata[37:32];

    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;
    assign m_tvalid = ovalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
        end
        sr_reg    <= sr_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        sr_next     = sr_reg;
        rem_next    = rem_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_RUN;
                    case (action_t'(s_tuser))
                        ACT_CODE: begin
                            sr_next  = in_value;
                            rem_next = (in_length > CODE_CAP_W) ? CODE_CAP_W : in_length;
                        end
                        ACT_BYTE: begin
                            sr_next  = {24'd0, in_value[7:0]};
                            rem_next = BYTE_BITS;
                        end
                        ACT_WORD: begin
                            sr_next  = in_value;
                            rem_next = WORD_BITS;
                        end
                        ACT_FINISH: begin
                            // Zero padding up to the byte boundary, if any bits wait.
                            sr_next  = '0;
                            rem_next = (cnt_reg != 3'd0) ? (6'd8 - {3'd0, cnt_reg}) : 6'd0;
                        end
                        default: begin
                            sr_next  = sr_reg;
                            rem_next = '0;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    pend_next = step_out.pend;
                    cnt_next  = step_out.cnt;
                    sr_next   = step_out.sr;
                    rem_next  = step_out.rem;
                    if (step_out.emit) begin
                        obyte_next  = step_out.obyte;
                        olast_next  = step_out.last;
                        ovalid_next = 1'b1;
                    end
                    if (!step_out.emit || step_out.rem == 6'd0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The bit budget of one item never exceeds a full word.
    `MFBP_ASSERT_NOW(a_rem_bound, 1'b1, rem_reg <= WORD_BITS, "bit budget out of range")
    // A finish item loads exactly the padding that completes the queued byte.
    `MFBP_ASSERT_NEXT(a_finish_pad, in_accept && s_tuser == ACT_FINISH,
        (rem_reg == 6'd0 && cnt_reg == 3'd0) || (rem_reg + {3'd0, cnt_reg} == 6'd8),
        "finish padding mismatch")
    // An exhausted budget with a free output returns the sequencer to idle.
    `MFBP_ASSERT_NEXT(a_run_done, state_reg == ST_RUN && rem_reg == 6'd0 && out_free,
        state_reg == ST_IDLE, "sequencer failed to finish")
    // A stalled output byte is never overwritten by the merge unit.
    `MFBP_ASSERT_NEXT(a_no_overrun, ovalid_reg && !m_tready,
        ovalid_reg && $stable(obyte_reg) && $stable(olast_reg), "output byte overwritten")

endmodule

`default_nettype wire

// ===== rtl/mfbp_merge_unit.sv =====
// Shared merge unit: one step of the packer, either completing a byte from
// the queued bits plus new bits, or absorbing the remaining bits. Uses mfbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfbp_merge_unit
    import mfbp_pkg::*;
(
    input  step_in_t  si,
    output step_out_t so
);

    // Bit at position p counted from the oldest queued bit.
    function automatic logic pick_bit(input logic [2:0] p, input step_in_t s);
        logic [2:0] idx;
        logic [7:0] sr_lo;
        logic       r;
        sr_lo = s.sr[7:0];
        if (p < s.cnt) begin
            idx = s.cnt - p - 3'd1;
            r   = s.pend[idx];
        end else begin
            idx = p - s.cnt;
            r   = sr_lo[idx];
        end
        return r;
    endfunction

    logic [3:0] need;
    logic       take;
    logic [2:0] new_cnt;

    always_comb begin
        need    = 4'd8 - {1'b0, si.cnt};
        take    = (si.rem >= {2'b00, need});
        new_cnt = si.cnt + si.rem[2:0];

        so.emit = take;
        for (int j = 0; j < 8; j++) begin
            so.obyte[j] = pick_bit(3'(7 - j), si);
        end

        if (take) begin
            so.pend = '0;
            so.cnt  = '0;
            so.sr   = si.sr >> need;
            so.rem  = si.rem - {2'b00, need};
            so.last = ((si.rem - {2'b00, need}) < BYTE_BITS);
        end else begin
            for (int q = 0; q < 7; q++) begin
                if (3'(q) < new_cnt) begin
                    so.pend[q] = pick_bit(new_cnt - 3'(q) - 3'd1, si);
                end else begin
                    so.pend[q] = 1'b0;
                end
            end
            so.cnt  = new_cnt;
            so.sr   = si.sr;
            so.rem  = '0;
            so.last = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== sim/packed_byte_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the MSB-first bit packer: watches both streams, predicts the
// packed bytes of each accepted item and compares them in order. Uses mfbp_pkg.

module packed_byte_checker
    import mfbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    output int          mismatches,
    output int          open_results
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_byte_t;

    packed_byte_t expected_bytes[$];

    // Bits queued in the packer but not yet part of a whole byte.
    logic [6:0] queued_bits;
    logic [2:0] queued_count;

    task automatic predict_item(input action_t act, input logic [31:0] value,
                                input logic [5:0] length);
        logic [7:0]  acc;
        logic [31:0] bits;
        logic [7:0]  made[4];
        int          made_n;
        int          fill;
        int          nbits;
        int          i;
        acc    = {1'b0, queued_bits};
        fill   = queued_count;
        made_n = 0;
        bits   = value;
        nbits  = 0;
        case (act)
            ACT_CODE: begin
                nbits = (length > CODE_CAP) ? CODE_CAP : length;
            end
            ACT_BYTE: begin
                bits  = {24'b0, value[7:0]};
                nbits = 8;
            end
            ACT_WORD: begin
                nbits = 32;
            end
            default: begin
                nbits = 0;
            end
        endcase
        for (i = 0; i < nbits; i++) begin
            acc  = {acc[6:0], bits[i]};
            fill = fill + 1;
            if (fill == 8) begin
                made[made_n] = acc;
                made_n       = made_n + 1;
                acc          = '0;
                fill         = 0;
            end
        end
        if (act == ACT_FINISH) begin
            // Flush a partial byte, oldest bit at the top, zeros below.
            if (fill != 0) begin
                made[made_n] = acc << (8 - fill);
                made_n       = made_n + 1;
            end
            acc  = '0;
            fill = 0;
        end
        for (i = 0; i < made_n; i++) begin
            expected_bytes.insert(expected_bytes.size(), {made[i], i == made_n - 1});
        end
        queued_bits  = acc[6:0];
        queued_count = fill[2:0];
    endtask

    always @(posedge aclk) begin
        packed_byte_t want;
        if (!aresetn) begin
            expected_bytes.delete();
            queued_bits  = '0;
            queued_count = '0;
            mismatches   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(action_t'(s_tuser), s_tdata[31:0], s_tdata[37:32]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte transfer, actual data %02h last %0b",
                             $time, m_tdata, m_tlast);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_bytes[0];
                    expected_bytes.delete(0);
                    if (m_tdata !== want.data) begin
                        $display("%0t: data mismatch, expected %02h actual %02h",
                                 $time, want.data, m_tdata);
                        mismatches = mismatches + 1;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last mismatch, expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        open_results = expected_bytes.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the bit packer testbench: clock, reset, stimulus and the verdict.
// Depends on mfbp_pkg, msb_first_bit_packer and packed_byte_checker.

module testbench;
    import mfbp_pkg::*;

    // Generous cycle budget for the whole run.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 220;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    int mismatches;
    int open_results;
    int cycles = 0;
    int items_sent;
    int directed_items;
    int bytes_seen = 0;
    int stall_left = 0;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit no_idle;

    msb_first_bit_packer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    packed_byte_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .mismatches   (mismatches),
        .open_results (open_results)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Idle stretch length: in eight draws of ten from the short range, else a long
    // one, so that the output register fills and the sequencer has to wait.
    function automatic int idle_span();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Receiver back-pressure. While no stall runs, a new one starts with a chance of
    // one in four unless idling is switched off for the current stretch of items.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= idle_span();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            bytes_seen <= bytes_seen + 1;
        end
    end

    // Watchdog: a hung handshake or a lost byte ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles,
                     open_results);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Presents one item and holds it until the packer takes it. The task is
    // entered and left right after a rising edge, so back-to-back items keep
    // tvalid high without a second assignment in the same time step.
    task automatic send_item(input action_t act, input logic [31:0] value,
                             input logic [5:0] length);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            gap = idle_span();
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= act;
        s_tdata  <= {2'b00, length, value};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent = items_sent + 1;
    endtask

    initial begin
        action_t     act;
        logic [31:0] value;
        logic [5:0]  length;
        int          pick;
        int          n;

        // Every block input has a known value before the first clock edge.
        aresetn    = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_CODE;
        s_tvalid   = 1'b0;
        no_idle    = 1'b0;
        items_sent = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: single bits, both kinds of finish, the full and the
        // saturated code lengths, ignored upper byte bits and misaligned words.
        send_item(ACT_CODE,   32'h0000_0001, 6'd1);
        send_item(ACT_CODE,   32'hDEAD_BEEF, 6'd0);   // zero length adds nothing
        send_item(ACT_FINISH, 32'hFFFF_FFFF, 6'd63);  // one queued bit padded out
        send_item(ACT_FINISH, 32'h0000_0000, 6'd0);   // empty queue, no byte
        send_item(ACT_CODE,   32'hFFFF_FFFF, 6'd32);
        send_item(ACT_CODE,   32'hA5A5_5A5A, 6'd63);  // overlong, capped at 32
        send_item(ACT_CODE,   32'h0F0F_3C3C, 6'd33);
        send_item(ACT_BYTE,   32'hFFFF_FF00, 6'd63);  // upper bits must be dropped
        send_item(ACT_BYTE,   32'h0000_00FF, 6'd0);
        send_item(ACT_WORD,   32'h0000_0000, 6'd21);
        send_item(ACT_WORD,   32'hFFFF_FFFF, 6'd0);
        send_item(ACT_CODE,   32'h0000_0005, 6'd3);
        send_item(ACT_WORD,   32'h1234_5678, 6'd42);  // word across a byte boundary
        send_item(ACT_BYTE,   32'h0000_00C3, 6'd7);
        send_item(ACT_CODE,   32'h0000_002B, 6'd7);
        send_item(ACT_FINISH, 32'h0000_0000, 6'd0);   // two queued bits
        send_item(ACT_CODE,   32'h0000_0013, 6'd5);
        send_item(ACT_CODE,   32'h8000_0000, 6'd32);
        send_item(ACT_FINISH, 32'h0000_0000, 6'd0);
        send_item(ACT_CODE,   32'h0000_0001, 6'd2);
        send_item(ACT_FINISH, 32'h5555_5555, 6'd31);
        directed_items = items_sent;

        // Random part. Every fourth block of thirty items runs without idling.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = ((n / 30) % 4 == 1);
            pick    = $urandom_range(0, 99);
            length  = 6'($urandom);
            if (pick < 45) begin
                act  = ACT_CODE;
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    length = 6'd0;
                end else if (pick == 1) begin
                    length = 6'($urandom_range(33, 63));
                end else begin
                    length = 6'($urandom_range(1, 32));
                end
            end else if (pick < 65) begin
                act = ACT_BYTE;
            end else if (pick < 85) begin
                act = ACT_WORD;
            end else begin
                act = ACT_FINISH;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                value = '0;
            end else if (pick == 1) begin
                value = '1;
            end else begin
                value = $urandom;
            end
            send_item(act, value, length);
        end
        s_tvalid <= 1'b0;
        no_idle  = 1'b0;

        // Wait for every predicted byte, then give the packer time to show
        // any stray output before judging.
        do @(posedge aclk); while (open_results != 0);
        repeat (20) @(posedge aclk);

        $display("summary: %0d input transfers (%0d directed, the rest random)",
                 items_sent, directed_items);
        $display("summary: %0d packed bytes compared against the prediction", bytes_seen);
        if (mismatches == 0 && open_results == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
